// ----- rtl/bbmbr_pkg.sv -----
// Shared types and constants for the bounding-box message to bearing/range block.
package bbmbr_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned CoordW  = 11;
  localparam int unsigned OffsetW = 12;
  localparam int unsigned WidthW  = 10;
  localparam int unsigned ColourW = 3;
  localparam int unsigned BearW   = 9;
  localparam int unsigned DistW   = 7;
  localparam int unsigned RemW    = 13;
  localparam int unsigned DvsW    = WidthW + DistW - 1;

  localparam logic [WordW-1:0] StartTail   = {16'h0000, 8'h42, 8'h42};
  localparam logic [WordW-1:0] StartRed    = {8'h00, 8'h52, 16'h0000} | StartTail;
  localparam logic [WordW-1:0] StartGreen  = {8'h00, 8'h47, 16'h0000} | StartTail;
  localparam logic [WordW-1:0] StartBlue   = {8'h00, 8'h42, 16'h0000} | StartTail;
  localparam logic [WordW-1:0] StartYellow = {8'h00, 8'h59, 16'h0000} | StartTail;
  localparam logic [WordW-1:0] StartPink   = {8'h00, 8'h50, 16'h0000} | StartTail;

  localparam logic [ColourW-1:0] ColourRed    = 3'd0;
  localparam logic [ColourW-1:0] ColourGreen  = 3'd1;
  localparam logic [ColourW-1:0] ColourBlue   = 3'd2;
  localparam logic [ColourW-1:0] ColourYellow = 3'd3;
  localparam logic [ColourW-1:0] ColourPink   = 3'd4;

  localparam logic signed [OffsetW-1:0] CentreCol = 12'sd320;
  localparam logic signed [OffsetW-1:0] WidthLow  = 12'sd50;
  localparam logic signed [OffsetW-1:0] WidthHigh = 12'sd580;
  localparam logic [RemW-1:0]           DistNum   = 13'd4900;
  // Reciprocal of 13 scaled by 2^16, rounded up; exact for offsets below 6000.
  localparam logic [12:0]               Recip13   = 13'd5042;
  localparam logic [2:0]                LastStep  = 3'(DistW - 1);

  typedef enum logic [1:0] {
    STAGE_IDLE = 2'd0,
    STAGE_X    = 2'd1,
    STAGE_Y    = 2'd2
  } stage_e;

  typedef enum logic [1:0] {
    BACK_IDLE   = 2'd0,
    BACK_DIV    = 2'd1,
    BACK_FINISH = 2'd2
  } back_state_e;

  typedef struct packed {
    logic [ColourW-1:0]        colour;
    logic signed [OffsetW-1:0] offset;
    logic [WidthW-1:0]         width;
  } job_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } queue_stat_t;

endpackage

// ----- rtl/bbmbr_front.sv -----
// Front end: word parser that tracks the stage and colour and queues in-band boxes.
module bbmbr_front import bbmbr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic             cfg_bypass_parsing_i,
  input  logic             message_valid_i,
  output logic             message_ready_o,
  input  logic [WordW-1:0] message_word_i,
  input  queue_stat_t      q_stat_i,
  output logic             push_o,
  output job_t             job_o
);

  stage_e              stage_q, stage_d;
  logic [ColourW-1:0]  colour_q, colour_d;
  logic                bypass_q;
  logic                accept;
  logic                is_start;
  logic [ColourW-1:0]  start_colour;
  logic [CoordW-1:0]   x_min, x_max;
  logic signed [OffsetW-1:0] width;
  logic [OffsetW-1:0]  sum;
  logic [CoordW-1:0]   centre;
  logic                in_band;

  assign message_ready_o = q_stat_i.not_full;
  assign accept = message_valid_i && message_ready_o && !bypass_q;

  always_comb begin
    is_start     = 1'b1;
    start_colour = ColourRed;
    unique case (message_word_i)
      StartRed:    start_colour = ColourRed;
      StartGreen:  start_colour = ColourGreen;
      StartBlue:   start_colour = ColourBlue;
      StartYellow: start_colour = ColourYellow;
      StartPink:   start_colour = ColourPink;
      default:     is_start = 1'b0;
    endcase
  end

  assign x_min   = message_word_i[26:16];
  assign x_max   = message_word_i[10:0];
  assign width   = $signed({1'b0, x_max}) - $signed({1'b0, x_min});
  assign sum     = {1'b0, x_min} + {1'b0, x_max};
  assign centre  = sum[OffsetW-1:1];
  assign in_band = (width > WidthLow) && (width < WidthHigh);

  always_comb begin
    stage_d  = stage_q;
    colour_d = colour_q;
    push_o   = 1'b0;
    if (accept) begin
      if (is_start) begin
        colour_d = start_colour;
        stage_d  = STAGE_X;
      end else begin
        unique case (stage_q)
          STAGE_X: begin
            stage_d = STAGE_Y;
            push_o  = in_band;
          end
          STAGE_Y: stage_d = STAGE_IDLE;
          default: stage_d = stage_q;
        endcase
      end
    end
  end

  assign job_o.colour = colour_q;
  assign job_o.offset = $signed({1'b0, centre}) - CentreCol;
  assign job_o.width  = width[WidthW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q  <= STAGE_IDLE;
      colour_q <= ColourRed;
      bypass_q <= 1'b0;
    end else begin
      stage_q  <= stage_d;
      colour_q <= colour_d;
      if (cfg_valid_i) begin
        bypass_q <= cfg_bypass_parsing_i;
      end
    end
  end

endmodule

// ----- rtl/bbmbr_queue.sv -----
// Two-entry queue of parsed boxes between the parser and the divider.
module bbmbr_queue import bbmbr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  job_t        job_i,
  input  logic        pop_i,
  output job_t        job_o,
  output queue_stat_t stat_o
);

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign stat_o.not_empty = (count_q != 2'd0);
  assign stat_o.not_full  = (count_q != 2'd2);
  assign job_o            = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- rtl/bbmbr_back.sv -----
// Back end: bearing by reciprocal multiply, range by a bit-serial divider, output register.
module bbmbr_back import bbmbr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  queue_stat_t        q_stat_i,
  input  job_t               job_i,
  output logic               pop_o,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic [ColourW-1:0] colour_code_o,
  output logic signed [BearW-1:0] bearing_o,
  output logic [DistW-1:0]   distance_o
);

  back_state_e         state_q, state_d;
  logic [2:0]          step_q;
  logic [RemW-1:0]     rem_q;
  logic [DvsW-1:0]     dvs_q;
  logic [DistW-1:0]    quo_q;
  logic [ColourW-1:0]  colour_q;
  logic signed [BearW-1:0] bear_q;
  logic                out_valid_q;
  logic [ColourW-1:0]  out_colour_q;
  logic signed [BearW-1:0] out_bear_q;
  logic [DistW-1:0]    out_dist_q;

  logic                load;
  logic                finish;
  logic                off_neg;
  logic [OffsetW-1:0]  mag;
  logic [23:0]         prod;
  logic [BearW-1:0]    quot_mag;
  logic                fits;

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign off_neg  = job_i.offset[OffsetW-1];
  assign mag      = off_neg ? OffsetW'(-job_i.offset) : OffsetW'(job_i.offset);
  assign prod     = mag[CoordW-1:0] * Recip13;
  assign quot_mag = {1'b0, prod[23:16]};
  assign fits     = ({3'b000, rem_q} >= dvs_q);

  always_comb begin
    state_d = state_q;
    load    = 1'b0;
    finish  = 1'b0;
    unique case (state_q)
      BACK_IDLE: begin
        if (q_stat_i.not_empty) begin
          load    = 1'b1;
          state_d = BACK_DIV;
        end
      end
      BACK_DIV: begin
        if (step_q == LastStep) begin
          state_d = BACK_FINISH;
        end
      end
      BACK_FINISH: begin
        if (!out_valid_q || result_ready_i) begin
          finish  = 1'b1;
          state_d = BACK_IDLE;
        end
      end
      default: state_d = BACK_IDLE;
    endcase
  end

  assign pop_o = load;

  always_ff @(posedge clk_i) begin
    if (load) begin
      rem_q    <= DistNum;
      dvs_q    <= {job_i.width, {(DistW-1){1'b0}}};
      quo_q    <= '0;
      colour_q <= job_i.colour;
      bear_q   <= off_neg ? $signed(-quot_mag) : $signed(quot_mag);
    end else if (state_q == BACK_DIV) begin
      if (fits) begin
        rem_q <= rem_q - dvs_q[RemW-1:0];
      end
      quo_q <= {quo_q[DistW-2:0], fits};
      dvs_q <= dvs_q >> 1;
    end
    if (finish) begin
      out_colour_q <= colour_q;
      out_bear_q   <= bear_q;
      out_dist_q   <= quo_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BACK_IDLE;
      step_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        step_q <= 3'd0;
      end else if (state_q == BACK_DIV) begin
        step_q <= step_q + 3'd1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (result_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign result_valid_o = out_valid_q;
  assign colour_code_o  = out_colour_q;
  assign bearing_o      = out_bear_q;
  assign distance_o     = out_dist_q;

endmodule

// ----- rtl/bbox_message_to_bearing_range.sv -----
// Top level: turns detector message words into colour, bearing and range reports.
//
// Message words enter on message_valid_i/message_ready_o/message_word_i. A start
// word selects the colour; the next word carries x_min and x_max; the word after
// that is consumed silently. Boxes whose width lies between 51 and 579 produce
// one report on result_valid_o/result_ready_i with colour_code_o, bearing_o and
// distance_o. The configuration channel (cfg_valid_i, cfg_ready_o,
// cfg_bypass_parsing_i) is always ready; with bypass set every word is taken and
// dropped with no change of state.
// The parser takes one word per cycle while its two-entry queue has room. Each
// report passes through the range divider in order (load, 7 quotient bits, hand-off);
// the divider works on one report at a time and loads the next only after handing
// off the last. Reports reach the output via the queue, divider and output register.
// Reset clears the stage to idle, the colour to red, bypass to off and empties
// the queue and output register. A stalled receiver holds the report; the
// divider finishes the next one and waits, then the queue fills and
// message_ready_o drops.
module bbox_message_to_bearing_range import bbmbr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_bypass_parsing_i,
  input  logic               message_valid_i,
  output logic               message_ready_o,
  input  logic [WordW-1:0]   message_word_i,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic [ColourW-1:0] colour_code_o,
  output logic signed [BearW-1:0] bearing_o,
  output logic [DistW-1:0]   distance_o
);

  queue_stat_t q_stat;
  logic        push, pop;
  job_t        job_in, job_out;

  assign cfg_ready_o = 1'b1;

  bbmbr_front u_front (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_valid_i          (cfg_valid_i),
    .cfg_bypass_parsing_i (cfg_bypass_parsing_i),
    .message_valid_i      (message_valid_i),
    .message_ready_o      (message_ready_o),
    .message_word_i       (message_word_i),
    .q_stat_i             (q_stat),
    .push_o               (push),
    .job_o                (job_in)
  );

  bbmbr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  bbmbr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_stat_i       (q_stat),
    .job_i          (job_out),
    .pop_o          (pop),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .colour_code_o  (colour_code_o),
    .bearing_o      (bearing_o),
    .distance_o     (distance_o)
  );

  // The range must fall within what the width band allows.
  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (distance_o >= 7'd8) && (distance_o <= 7'd96))
    else $error("distance out of range");

  a_colour_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (colour_code_o <= ColourPink))
    else $error("colour code out of range");

  a_bearing_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (bearing_o >= -9'sd22) && (bearing_o <= 9'sd132))
    else $error("bearing out of range");

  // The queue is never popped while empty.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> q_stat.not_empty)
    else $error("queue popped while empty");

endmodule

// ----- sim/tb_bbox_message_to_bearing_range.sv -----
// Self-checking testbench for the bounding-box message to bearing/range block.
module tb_bbox_message_to_bearing_range;
  import bbmbr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit   = 600000;
  localparam int SettleCycles = 30;
  localparam int BearingStep  = 13;
  localparam int CoordMax     = 2047;

  typedef enum logic {
    RX_STEADY = 1'b0,
    RX_RANDOM = 1'b1
  } rx_mode_e;

  typedef struct packed {
    logic [ColourW-1:0]      colour;
    logic signed [BearW-1:0] bearing;
    logic [DistW-1:0]        distance;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic cfg_bypass_parsing_i = 1'b0;
  logic message_valid_i = 1'b0;
  logic message_ready_o;
  logic [WordW-1:0] message_word_i = '0;
  logic result_valid_o;
  logic result_ready_i = 1'b0;
  logic [ColourW-1:0] colour_code_o;
  logic signed [BearW-1:0] bearing_o;
  logic [DistW-1:0] distance_o;

  // Shadow of the block's parser state, advanced on every accepted word while bypass is off.
  stage_e stage_q = STAGE_IDLE;
  logic [ColourW-1:0] colour_q = ColourRed;
  logic bypass_q = 1'b0;
  report_t pending_reports[$];

  int err_count = 0;
  int cycle_count = 0;
  bit tx_gaps = 1'b1;
  rx_mode_e rx_mode = RX_RANDOM;
  int rx_hold_len = 0;
  int hold_left = 0;
  int stall_left = 0;

  bbox_message_to_bearing_range dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_bypass_parsing_i(cfg_bypass_parsing_i),
    .message_valid_i     (message_valid_i),
    .message_ready_o     (message_ready_o),
    .message_word_i      (message_word_i),
    .result_valid_o      (result_valid_o),
    .result_ready_i      (result_ready_i),
    .colour_code_o       (colour_code_o),
    .bearing_o           (bearing_o),
    .distance_o          (distance_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WordW-1:0] start_word(input logic [ColourW-1:0] col);
    case (col)
      ColourRed:    return StartRed;
      ColourGreen:  return StartGreen;
      ColourBlue:   return StartBlue;
      ColourYellow: return StartYellow;
      default:      return StartPink;
    endcase
  endfunction

  function automatic logic [WordW-1:0] random_start();
    return start_word(ColourW'($urandom_range(0, 4)));
  endfunction

  function automatic logic [WordW-1:0] box_word(input int xmin, input int xmax,
                                                input logic [4:0] hi, input logic [4:0] lo);
    return {hi, CoordW'(xmin), lo, CoordW'(xmax)};
  endfunction

  // Builds an x word; out-of-band boxes are narrow, too wide or a fully random word.
  function automatic logic [WordW-1:0] random_box(input bit in_band);
    int w;
    int xmin;
    int pick;
    if (in_band) begin
      w = $urandom_range(51, 579);
      xmin = $urandom_range(0, CoordMax - w);
      return box_word(xmin, xmin + w, 5'($urandom), 5'($urandom));
    end
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      w = $urandom_range(0, 50);
      xmin = $urandom_range(0, CoordMax - w);
      return box_word(xmin, xmin + w, 5'($urandom), 5'($urandom));
    end
    if (pick == 1) begin
      w = $urandom_range(580, CoordMax);
      xmin = $urandom_range(0, CoordMax - w);
      return box_word(xmin, xmin + w, 5'($urandom), 5'($urandom));
    end
    return $urandom;
  endfunction

  // Advances the shadow parser by one word and queues the report it causes.
  function automatic void parse_word(input logic [WordW-1:0] w);
    int xmin;
    int xmax;
    int width;
    int centre;
    bit is_start;
    logic [ColourW-1:0] col;
    report_t rep;
    if (bypass_q) return;
    is_start = 1'b1;
    col = ColourRed;
    case (w)
      StartRed:    col = ColourRed;
      StartGreen:  col = ColourGreen;
      StartBlue:   col = ColourBlue;
      StartYellow: col = ColourYellow;
      StartPink:   col = ColourPink;
      default:     is_start = 1'b0;
    endcase
    if (is_start) begin
      colour_q = col;
      stage_q = STAGE_X;
      return;
    end
    case (stage_q)
      STAGE_X: begin
        xmin = int'(w[26:16]);
        xmax = int'(w[10:0]);
        width = xmax - xmin;
        stage_q = STAGE_Y;
        if (width > int'(WidthLow) && width < int'(WidthHigh)) begin
          centre = (xmin + xmax) / 2;
          rep.colour = colour_q;
          rep.bearing = BearW'((centre - int'(CentreCol)) / BearingStep);
          rep.distance = DistW'(int'(DistNum) / width);
          pending_reports.push_back(rep);
        end
      end
      STAGE_Y: stage_q = STAGE_IDLE;
      default: ;
    endcase
  endfunction

  // Inputs are predicted before outputs are checked within the same edge.
  always @(posedge clk_i) begin
    report_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) bypass_q = cfg_bypass_parsing_i;
      if (message_valid_i && message_ready_o) parse_word(message_word_i);
      if (result_valid_o && result_ready_i) begin
        if (pending_reports.size() == 0) begin
          $display("%0t: unexpected report colour %0d bearing %0d distance %0d",
                   $time, colour_code_o, bearing_o, distance_o);
          err_count++;
        end else begin
          want = pending_reports.pop_front();
          if (colour_code_o !== want.colour) begin
            $display("%0t: colour expected %0d actual %0d", $time, want.colour, colour_code_o);
            err_count++;
          end
          if (bearing_o !== want.bearing) begin
            $display("%0t: bearing expected %0d actual %0d", $time, want.bearing, bearing_o);
            err_count++;
          end
          if (distance_o !== want.distance) begin
            $display("%0t: distance expected %0d actual %0d",
                     $time, want.distance, distance_o);
            err_count++;
          end
        end
      end
    end
  end

  // Receiver: a requested hold-off wins over the steady or random ready pattern.
  initial begin
    forever begin
      @(posedge clk_i);
      if (rx_hold_len != 0) begin
        hold_left = rx_hold_len;
        rx_hold_len = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready_i <= 1'b0;
      end else if (rx_mode == RX_STEADY) begin
        result_ready_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Valid stays high across back-to-back transactions and drops only for a gap or while waiting for reports.
  task automatic send_word(input logic [WordW-1:0] w);
    int gap;
    message_valid_i <= 1'b1;
    message_word_i <= w;
    @(posedge clk_i);
    while (!message_ready_o) @(posedge clk_i);
    gap = tx_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      message_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_reports();
    message_valid_i <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_bypass(input logic value);
    wait_for_reports();
    cfg_valid_i <= 1'b1;
    cfg_bypass_parsing_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_random_traffic(input int n_items);
    int sent;
    int r;
    logic [WordW-1:0] s;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 75) begin
        send_word(random_start());
        send_word(random_box($urandom_range(0, 99) < 85));
        send_word($urandom);
        sent += 3;
      end else if (r < 85) begin
        send_word($urandom);
        sent++;
      end else if (r < 92) begin
        send_word(random_start());
        sent++;
      end else if (r < 97) begin
        send_word(random_start());
        send_word(random_box(1'b1));
        sent += 2;
      end else begin
        // A word one bit away from a start word; it is a start only if it equals another start word.
        s = random_start();
        s[$urandom_range(0, WordW - 1)] ^= 1'b1;
        send_word(s);
        sent++;
      end
    end
  endtask

  task automatic test_idle_words();
    send_word('1);
    send_word('0);
  endtask

  task automatic test_colours_and_widths();
    send_word(StartRed);
    send_word(box_word(0, 51, 5'h1F, 5'h1F));
    send_word('1);
    send_word(StartGreen);
    send_word(box_word(0, 50, 5'h00, 5'h00));
    send_word('0);
    send_word(StartBlue);
    send_word(box_word(1996, CoordMax, 5'h1F, 5'h00));
    send_word($urandom);
    send_word(StartYellow);
    send_word(box_word(0, 580, 5'h00, 5'h1F));
    send_word(StartPink);
    send_word(box_word(0, 579, 5'h15, 5'h0A));
    send_word($urandom);
    send_word(StartRed);
    send_word(box_word(CoordMax, 0, 5'h0A, 5'h15));
    send_word($urandom);
  endtask

  task automatic test_start_wins();
    send_word(StartRed);
    send_word(StartGreen);
    send_word(box_word(100, 300, 5'h00, 5'h00));
    send_word(StartBlue);
    send_word(box_word(400, 600, 5'h1F, 5'h1F));
    send_word($urandom);
  endtask

  // Words under bypass must leave the pending stage and colour untouched.
  task automatic test_bypass_holds_state();
    send_word(StartYellow);
    write_bypass(1'b1);
    send_word(StartRed);
    send_word(random_box(1'b1));
    send_random_traffic(20);
    write_bypass(1'b0);
    send_word(box_word(700, 900, 5'h00, 5'h00));
    send_word($urandom);
  endtask

  task automatic test_receiver_holdoff();
    tx_gaps = 1'b0;
    rx_hold_len = 400;
    repeat (40) begin
      send_word(random_start());
      send_word(random_box(1'b1));
      send_word($urandom);
    end
    wait_for_reports();
    tx_gaps = 1'b1;
  endtask

  task automatic test_random_traffic();
    send_random_traffic(500);
    wait_for_reports();
    tx_gaps = 1'b0;
    rx_mode = RX_STEADY;
    send_random_traffic(300);
    wait_for_reports();
    tx_gaps = 1'b1;
    rx_mode = RX_RANDOM;
    write_bypass(1'b1);
    send_random_traffic(60);
    write_bypass(1'b0);
    send_random_traffic(400);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_bypass(1'b0);
    test_idle_words();
    test_colours_and_widths();
    test_start_wins();
    test_bypass_holds_state();
    test_receiver_holdoff();
    test_random_traffic();
    wait_for_reports();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- bbox_message_to_bearing_range.f -----
rtl/bbmbr_pkg.sv
rtl/bbmbr_front.sv
rtl/bbmbr_queue.sv
rtl/bbmbr_back.sv
rtl/bbox_message_to_bearing_range.sv
sim/tb_bbox_message_to_bearing_range.sv
